// ===== rtl/core/segi_pkg.sv =====
package segi_pkg;

   localparam int CoordWidth    = 16;
   localparam int FracBits      = 8;
   localparam int DiffWidth     = CoordWidth + 1;
   localparam int ProdWidth     = 2 * DiffWidth;
   localparam int CrossWidth    = ProdWidth + 1;
   localparam int MagWidth      = CrossWidth - 1;
   localparam int NumWidth      = MagWidth + CoordWidth;
   localparam int DividendWidth = NumWidth + FracBits;
   localparam int QuotWidth     = CoordWidth + FracBits;
   localparam int OutWidth      = CoordWidth + FracBits;

   typedef enum logic [1:0] {
      StatusHit        = 2'd0,
      StatusNoCross    = 2'd1,
      StatusDegenerate = 2'd2,
      StatusParallel   = 2'd3
   } status_type;

   typedef struct packed {
      logic signed [CoordWidth-1:0] first_start_x;
      logic signed [CoordWidth-1:0] first_start_y;
      logic signed [CoordWidth-1:0] first_end_x;
      logic signed [CoordWidth-1:0] first_end_y;
      logic signed [CoordWidth-1:0] second_start_x;
      logic signed [CoordWidth-1:0] second_start_y;
      logic signed [CoordWidth-1:0] second_end_x;
      logic signed [CoordWidth-1:0] second_end_y;
   } req_payload_type;

   typedef struct packed {
      logic                       hit;
      status_type                 status;
      logic signed [OutWidth-1:0] cross_x;
      logic signed [OutWidth-1:0] cross_y;
   } rsp_payload_type;

   typedef struct packed {
      logic                         valid;
      status_type                   status;
      logic signed [CoordWidth-1:0] base_x;
      logic signed [CoordWidth-1:0] base_y;
      logic                         neg_x;
      logic                         neg_y;
      logic [MagWidth-1:0]          den;
      logic [NumWidth-1:0]          num_x;
      logic [NumWidth-1:0]          num_y;
   } geom_out_type;

   typedef struct packed {
      status_type                   status;
      logic signed [CoordWidth-1:0] base;
      logic                         neg;
   } x_tag_type;

   typedef struct packed {
      logic signed [CoordWidth-1:0] base;
      logic                         neg;
   } y_tag_type;

   function automatic logic signed [DiffWidth-1:0] coord_diff(
      input logic signed [CoordWidth-1:0] hi,
      input logic signed [CoordWidth-1:0] lo
   );
      coord_diff = DiffWidth'(hi) - DiffWidth'(lo);
   endfunction

endpackage

// ===== rtl/core/segment_intersection_top.sv =====
// Segment intersection engine.
// One beat on the request channel (req_valid, req_ready, req_data) carries two
// segments, a-b and p1-p2, with signed 16-bit end points. One beat on the
// response channel (rsp_valid, rsp_ready, rsp_data) returns, for each request
// in order, a hit flag, a status code and the floored crossing point with
// eight fraction bits; the point is zero unless the segments meet.
// The pipeline takes a new request every cycle while the output is not stalled.
// Each request passes through five geometry stages (differences, cross product
// terms, determinants, classification, numerator products), 24 divider stages
// that each retire one quotient bit, and the output register.
// The x and y coordinates share the classification and run through two
// dividers side by side.
// When the receiver holds rsp_ready low while a response is waiting, the whole
// pipeline freezes and req_ready drops in the same cycle; nothing is dropped
// or duplicated, and the waiting response holds steady until taken.
// A synchronous reset clears every valid bit, so no response is presented
// until new requests arrive.
module segment_intersection_top (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  segi_pkg::req_payload_type req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output segi_pkg::rsp_payload_type rsp_data
);
   import segi_pkg::*;

   // The pipeline moves as one unit whenever the output register can be refilled.
   logic            advance;
   geom_out_type    geom;
   x_tag_type       x_tag_in, x_tag_out;
   y_tag_type       y_tag_in, y_tag_out;
   logic            x_valid, y_valid, x_rem_nz, y_rem_nz;
   logic [QuotWidth-1:0] x_quot, y_quot;

   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff, rsp_data_in;

   logic [OutWidth-1:0] x_point, y_point;
   logic                out_hit;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;

   segi_geom u_geom (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .in_valid (req_valid),
      .in_data  (req_data),
      .out_data (geom)
   );

   assign x_tag_in.status = geom.status;
   assign x_tag_in.base   = geom.base_x;
   assign x_tag_in.neg    = geom.neg_x;
   assign y_tag_in.base   = geom.base_y;
   assign y_tag_in.neg    = geom.neg_y;

   // The numerator is shifted up by the fraction bits so that the quotient
   // already carries them; the remainder only decides floor for negatives.
   segi_div #(
      .DivWidth (DividendWidth),
      .DenWidth (MagWidth),
      .QWidth   (QuotWidth),
      .TagWidth ($bits(x_tag_type))
   ) u_div_x (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .in_valid    (geom.valid),
      .in_dividend ({geom.num_x, {FracBits{1'b0}}}),
      .in_divisor  (geom.den),
      .in_tag      (x_tag_in),
      .out_valid   (x_valid),
      .out_quot    (x_quot),
      .out_rem_nz  (x_rem_nz),
      .out_tag     (x_tag_out)
   );

   segi_div #(
      .DivWidth (DividendWidth),
      .DenWidth (MagWidth),
      .QWidth   (QuotWidth),
      .TagWidth ($bits(y_tag_type))
   ) u_div_y (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .in_valid    (geom.valid),
      .in_dividend ({geom.num_y, {FracBits{1'b0}}}),
      .in_divisor  (geom.den),
      .in_tag      (y_tag_in),
      .out_valid   (y_valid),
      .out_quot    (y_quot),
      .out_rem_nz  (y_rem_nz),
      .out_tag     (y_tag_out)
   );

   // A negative offset is floored: -(q + nz) is written as ~q + !nz.
   always_comb begin
      x_point = (OutWidth'(x_tag_out.base) << FracBits)
              + (x_tag_out.neg ? ~x_quot : x_quot)
              + OutWidth'(x_tag_out.neg && !x_rem_nz);
      y_point = (OutWidth'(y_tag_out.base) << FracBits)
              + (y_tag_out.neg ? ~y_quot : y_quot)
              + OutWidth'(y_tag_out.neg && !y_rem_nz);
      out_hit = (x_tag_out.status == StatusHit);

      rsp_valid_in        = x_valid && y_valid;
      rsp_data_in.hit     = out_hit;
      rsp_data_in.status  = x_tag_out.status;
      rsp_data_in.cross_x = out_hit ? x_point : '0;
      rsp_data_in.cross_y = out_hit ? y_point : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== rtl/core/segi_geom.sv =====
module segi_geom (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      advance,
   input  logic                      in_valid,
   input  segi_pkg::req_payload_type in_data,
   output segi_pkg::geom_out_type    out_data
);
   import segi_pkg::*;

   // Stage 1: direction and offset vectors.
   logic                         s1_valid_ff, s1_valid_in;
   logic                         s1_degen_ff, s1_degen_in;
   logic signed [DiffWidth-1:0]  s1_dx_ff, s1_dx_in, s1_dy_ff, s1_dy_in;
   logic signed [DiffWidth-1:0]  s1_qx_ff, s1_qx_in, s1_qy_ff, s1_qy_in;
   logic signed [DiffWidth-1:0]  s1_wx_ff, s1_wx_in, s1_wy_ff, s1_wy_in;
   logic signed [CoordWidth-1:0] s1_ax_ff, s1_ax_in, s1_ay_ff, s1_ay_in;

   // Stage 2: the six cross product terms.
   logic                         s2_valid_ff, s2_degen_ff;
   logic signed [ProdWidth-1:0]  s2_dxqy_ff, s2_dxqy_in, s2_dyqx_ff, s2_dyqx_in;
   logic signed [ProdWidth-1:0]  s2_wxqy_ff, s2_wxqy_in, s2_wyqx_ff, s2_wyqx_in;
   logic signed [ProdWidth-1:0]  s2_wxdy_ff, s2_wxdy_in, s2_wydx_ff, s2_wydx_in;
   logic signed [DiffWidth-1:0]  s2_dx_ff, s2_dy_ff;
   logic signed [CoordWidth-1:0] s2_ax_ff, s2_ay_ff;

   // Stage 3: denominator and the two numerators.
   logic                         s3_valid_ff, s3_degen_ff;
   logic signed [CrossWidth-1:0] s3_den_ff, s3_den_in, s3_tn_ff, s3_tn_in, s3_sn_ff, s3_sn_in;
   logic signed [DiffWidth-1:0]  s3_dx_ff, s3_dy_ff;
   logic signed [CoordWidth-1:0] s3_ax_ff, s3_ay_ff;

   // Stage 4: classification and magnitudes.
   logic                         s4_valid_ff;
   status_type                   s4_status_ff, s4_status_in;
   logic [MagWidth-1:0]          s4_den_ff, s4_den_in, s4_tn_ff, s4_tn_in;
   logic [CoordWidth-1:0]        s4_mx_ff, s4_mx_in, s4_my_ff, s4_my_in;
   logic                         s4_nx_ff, s4_ny_ff;
   logic signed [CoordWidth-1:0] s4_ax_ff, s4_ay_ff;

   // Stage 5: numerators of the crossing offset.
   geom_out_type                 s5_ff, s5_in;

   logic                         den_pos, t_ok, s_ok;
   logic signed [CrossWidth-1:0] tn_abs, den_abs;
   logic signed [DiffWidth-1:0]  dx_abs, dy_abs;

   always_comb begin
      s1_valid_in = in_valid;
      s1_dx_in    = coord_diff(in_data.first_end_x, in_data.first_start_x);
      s1_dy_in    = coord_diff(in_data.first_end_y, in_data.first_start_y);
      s1_qx_in    = coord_diff(in_data.second_end_x, in_data.second_start_x);
      s1_qy_in    = coord_diff(in_data.second_end_y, in_data.second_start_y);
      s1_wx_in    = coord_diff(in_data.second_start_x, in_data.first_start_x);
      s1_wy_in    = coord_diff(in_data.second_start_y, in_data.first_start_y);
      s1_ax_in    = in_data.first_start_x;
      s1_ay_in    = in_data.first_start_y;
      s1_degen_in = ((in_data.first_end_x == in_data.first_start_x) &&
                     (in_data.first_end_y == in_data.first_start_y)) ||
                    ((in_data.second_end_x == in_data.second_start_x) &&
                     (in_data.second_end_y == in_data.second_start_y));
   end

   always_comb begin
      s2_dxqy_in = s1_dx_ff * s1_qy_ff;
      s2_dyqx_in = s1_dy_ff * s1_qx_ff;
      s2_wxqy_in = s1_wx_ff * s1_qy_ff;
      s2_wyqx_in = s1_wy_ff * s1_qx_ff;
      s2_wxdy_in = s1_wx_ff * s1_dy_ff;
      s2_wydx_in = s1_wy_ff * s1_dx_ff;
   end

   always_comb begin
      s3_den_in = CrossWidth'(s2_dxqy_ff) - CrossWidth'(s2_dyqx_ff);
      s3_tn_in  = CrossWidth'(s2_wxqy_ff) - CrossWidth'(s2_wyqx_ff);
      s3_sn_in  = CrossWidth'(s2_wxdy_ff) - CrossWidth'(s2_wydx_ff);
   end

   // With a negative denominator the ranges flip instead of negating up front.
   always_comb begin
      den_pos = !s3_den_ff[CrossWidth-1];
      t_ok    = den_pos ? (s3_tn_ff >= 0 && s3_tn_ff <= s3_den_ff)
                        : (s3_tn_ff <= 0 && s3_tn_ff >= s3_den_ff);
      s_ok    = den_pos ? (s3_sn_ff >= 0 && s3_sn_ff <= s3_den_ff)
                        : (s3_sn_ff <= 0 && s3_sn_ff >= s3_den_ff);
      tn_abs  = den_pos ? s3_tn_ff : -s3_tn_ff;
      den_abs = den_pos ? s3_den_ff : -s3_den_ff;
      dx_abs  = s3_dx_ff[DiffWidth-1] ? -s3_dx_ff : s3_dx_ff;
      dy_abs  = s3_dy_ff[DiffWidth-1] ? -s3_dy_ff : s3_dy_ff;
      if (s3_degen_ff) begin
         s4_status_in = StatusDegenerate;
      end else if (s3_den_ff == '0) begin
         s4_status_in = StatusParallel;
      end else if (t_ok && s_ok) begin
         s4_status_in = StatusHit;
      end else begin
         s4_status_in = StatusNoCross;
      end
      s4_den_in = den_abs[MagWidth-1:0];
      s4_tn_in  = (s4_status_in == StatusHit) ? tn_abs[MagWidth-1:0] : '0;
      s4_mx_in  = dx_abs[CoordWidth-1:0];
      s4_my_in  = dy_abs[CoordWidth-1:0];
   end

   always_comb begin
      s5_in.valid  = s4_valid_ff;
      s5_in.status = s4_status_ff;
      s5_in.base_x = s4_ax_ff;
      s5_in.base_y = s4_ay_ff;
      s5_in.neg_x  = s4_nx_ff;
      s5_in.neg_y  = s4_ny_ff;
      s5_in.den    = s4_den_ff;
      s5_in.num_x  = NumWidth'(s4_tn_ff) * NumWidth'(s4_mx_ff);
      s5_in.num_y  = NumWidth'(s4_tn_ff) * NumWidth'(s4_my_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_ff.valid <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
         s5_ff.valid <= s5_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_degen_ff <= s1_degen_in;
         s1_dx_ff    <= s1_dx_in;
         s1_dy_ff    <= s1_dy_in;
         s1_qx_ff    <= s1_qx_in;
         s1_qy_ff    <= s1_qy_in;
         s1_wx_ff    <= s1_wx_in;
         s1_wy_ff    <= s1_wy_in;
         s1_ax_ff    <= s1_ax_in;
         s1_ay_ff    <= s1_ay_in;

         s2_degen_ff <= s1_degen_ff;
         s2_dxqy_ff  <= s2_dxqy_in;
         s2_dyqx_ff  <= s2_dyqx_in;
         s2_wxqy_ff  <= s2_wxqy_in;
         s2_wyqx_ff  <= s2_wyqx_in;
         s2_wxdy_ff  <= s2_wxdy_in;
         s2_wydx_ff  <= s2_wydx_in;
         s2_dx_ff    <= s1_dx_ff;
         s2_dy_ff    <= s1_dy_ff;
         s2_ax_ff    <= s1_ax_ff;
         s2_ay_ff    <= s1_ay_ff;

         s3_degen_ff <= s2_degen_ff;
         s3_den_ff   <= s3_den_in;
         s3_tn_ff    <= s3_tn_in;
         s3_sn_ff    <= s3_sn_in;
         s3_dx_ff    <= s2_dx_ff;
         s3_dy_ff    <= s2_dy_ff;
         s3_ax_ff    <= s2_ax_ff;
         s3_ay_ff    <= s2_ay_ff;

         s4_status_ff <= s4_status_in;
         s4_den_ff    <= s4_den_in;
         s4_tn_ff     <= s4_tn_in;
         s4_mx_ff     <= s4_mx_in;
         s4_my_ff     <= s4_my_in;
         s4_nx_ff     <= s3_dx_ff[DiffWidth-1];
         s4_ny_ff     <= s3_dy_ff[DiffWidth-1];
         s4_ax_ff     <= s3_ax_ff;
         s4_ay_ff     <= s3_ay_ff;

         s5_ff.status <= s5_in.status;
         s5_ff.base_x <= s5_in.base_x;
         s5_ff.base_y <= s5_in.base_y;
         s5_ff.neg_x  <= s5_in.neg_x;
         s5_ff.neg_y  <= s5_in.neg_y;
         s5_ff.den    <= s5_in.den;
         s5_ff.num_x  <= s5_in.num_x;
         s5_ff.num_y  <= s5_in.num_y;
      end
   end

   assign out_data = s5_ff;

endmodule

// ===== rtl/core/segi_div.sv =====
module segi_div #(
   parameter int DivWidth = 58,
   parameter int DenWidth = 34,
   parameter int QWidth   = 24,
   parameter int TagWidth = 19
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic                in_valid,
   input  logic [DivWidth-1:0] in_dividend,
   input  logic [DenWidth-1:0] in_divisor,
   input  logic [TagWidth-1:0] in_tag,
   output logic                out_valid,
   output logic [QWidth-1:0]   out_quot,
   output logic                out_rem_nz,
   output logic [TagWidth-1:0] out_tag
);

   // One quotient bit per stage, most significant first.
   logic                valid_ff [QWidth];
   logic [DivWidth-1:0] rem_ff   [QWidth];
   logic [DenWidth-1:0] dvs_ff   [QWidth];
   logic [QWidth-1:0]   quot_ff  [QWidth];
   logic [TagWidth-1:0] tag_ff   [QWidth];

   logic                src_valid [QWidth];
   logic [DivWidth-1:0] src_rem   [QWidth];
   logic [DenWidth-1:0] src_dvs   [QWidth];
   logic [QWidth-1:0]   src_quot  [QWidth];
   logic [TagWidth-1:0] src_tag   [QWidth];

   for (genvar k = 0; k < QWidth; k++) begin : g_stage
      localparam int Bit = QWidth - 1 - k;

      logic [DivWidth:0]   trial;
      logic                take;
      logic [DivWidth-1:0] rem_in;
      logic [QWidth-1:0]   quot_in;

      if (k == 0) begin : g_first
         assign src_valid[k] = in_valid;
         assign src_rem[k]   = in_dividend;
         assign src_dvs[k]   = in_divisor;
         assign src_quot[k]  = '0;
         assign src_tag[k]   = in_tag;
      end else begin : g_next
         assign src_valid[k] = valid_ff[k-1];
         assign src_rem[k]   = rem_ff[k-1];
         assign src_dvs[k]   = dvs_ff[k-1];
         assign src_quot[k]  = quot_ff[k-1];
         assign src_tag[k]   = tag_ff[k-1];
      end

      always_comb begin
         trial        = {1'b0, src_rem[k]} - ((DivWidth + 1)'(src_dvs[k]) << Bit);
         take         = !trial[DivWidth];
         rem_in       = take ? trial[DivWidth-1:0] : src_rem[k];
         quot_in      = src_quot[k];
         quot_in[Bit] = take;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (advance) begin
            valid_ff[k] <= src_valid[k];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[k]  <= rem_in;
            dvs_ff[k]  <= src_dvs[k];
            quot_ff[k] <= quot_in;
            tag_ff[k]  <= src_tag[k];
         end
      end
   end

   assign out_valid  = valid_ff[QWidth-1];
   assign out_quot   = quot_ff[QWidth-1];
   assign out_rem_nz = |rem_ff[QWidth-1];
   assign out_tag    = tag_ff[QWidth-1];

endmodule

// ===== rtl/core/segi_checker.sv =====
module segi_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input segi_pkg::rsp_payload_type rsp_data
);
   import segi_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   a_hit_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.hit == (rsp_data.status == StatusHit)))
      else $error("hit flag disagrees with status");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.hit |-> rsp_data.cross_x == '0 && rsp_data.cross_y == '0)
      else $error("crossing point nonzero without a hit");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request taken while output stalled");

endmodule

bind segment_intersection_top segi_checker u_segi_checker (.*);
